// ===== hw/rtl/tcs_pkg.sv =====
// tcs_pkg: shared types and constants for the tile column shader
// no dependencies; imported by every module of the block
package tcs_pkg;

    localparam int NUM_PALETTES = 4;
    localparam int PAL_W        = 8;
    localparam int ROWS         = 8;
    localparam int ROW_W        = 16;
    localparam int PIX_W        = 2;
    localparam int HALF_W       = 64;
    localparam int COLUMN_W     = ROWS * PIX_W;
    localparam int CFG_IDX_W    = 8;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_ZERO  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_ONE   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_TWO   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_THREE = 8'd3;

    typedef logic [NUM_PALETTES-1:0][PAL_W-1:0] t_palette_bank;

    typedef struct packed {
        logic [HALF_W-1:0] rows_low;
        logic [HALF_W-1:0] rows_high;
        logic [1:0]        palette_select;
        logic              mirror_horizontal;
        logic              mirror_vertical;
        logic [2:0]        pixel_column;
    } t_tile_req;

    typedef struct packed {
        logic [COLUMN_W-1:0] column_word;
        logic                write_enable;
    } t_shade_res;

endpackage

// ===== hw/rtl/tile_column_shader.sv =====
// tile_column_shader: top level, input register, shading logic, result register
// depends on tcs_pkg, tcs_cfg and tcs_shade
//
// Shades one pixel column of an 8x8 tile of 2-bit pixels through one of four
// palette registers. One tile beat is accepted every clock cycle while ready
// is high; each beat passes through the input register and then the result
// register, with the shading logic between them. Ready goes low only while
// both registers hold beats and the result is not taken. Palette writes take
// effect on the next cycle; the user must make them only while the block is
// idle (not enforced by the block); writes to an index above three are ignored.
module tile_column_shader (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [tcs_pkg::HALF_W-1:0]    i_rows_low,
    input  logic [tcs_pkg::HALF_W-1:0]    i_rows_high,
    input  logic [1:0]                    i_palette_select,
    input  logic                          i_mirror_horizontal,
    input  logic                          i_mirror_vertical,
    input  logic [2:0]                    i_pixel_column,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [tcs_pkg::COLUMN_W-1:0]  o_column_word,
    output logic                          o_write_enable,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tcs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tcs_pkg::PAL_W-1:0]     i_cfg_data
);
    import tcs_pkg::*;

    t_palette_bank palettes;
    t_tile_req     r_req;
    t_shade_res    shade_res;
    t_shade_res    r_res;
    logic          r_in_vld;
    logic          r_out_vld;
    logic          n_in_vld;
    logic          n_out_vld;
    logic          advance;
    logic          take_in;

    assign o_cfg_ready = 1'b1;

    tcs_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (i_cfg_valid),
        .i_index    (i_cfg_index),
        .i_data     (i_cfg_data),
        .o_palettes (palettes)
    );

    // stage moves forward when the result register is free or being drained
    assign advance = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || !r_out_vld || i_ready;
    assign take_in = i_valid && o_ready;

    assign n_in_vld  = take_in || (r_in_vld && !advance);
    assign n_out_vld = advance || (r_out_vld && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_req.rows_low          <= i_rows_low;
            r_req.rows_high         <= i_rows_high;
            r_req.palette_select    <= i_palette_select;
            r_req.mirror_horizontal <= i_mirror_horizontal;
            r_req.mirror_vertical   <= i_mirror_vertical;
            r_req.pixel_column      <= i_pixel_column;
        end
        if (advance) begin
            r_res <= shade_res;
        end
    end

    tcs_shade u_shade (
        .i_req      (r_req),
        .i_palettes (palettes),
        .o_res      (shade_res)
    );

    assign o_valid        = r_out_vld;
    assign o_column_word  = r_res.column_word;
    assign o_write_enable = r_res.write_enable;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_vld && !r_out_vld)
        else $error("pipeline valid bits not cleared by reset");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_in |=> r_in_vld)
        else $error("accepted beat missing from input register");

    a_advance_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_vld)
        else $error("advanced beat missing from result register");

    a_no_write_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_res.write_enable) |-> (r_res.column_word == '0))
        else $error("blank tile result carries nonzero column");

endmodule

// ===== hw/rtl/tcs_cfg.sv =====
// tcs_cfg: the four palette registers and their write port
// depends on tcs_pkg
module tcs_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_we,
    input  logic [tcs_pkg::CFG_IDX_W-1:0] i_index,
    input  logic [tcs_pkg::PAL_W-1:0]    i_data,
    output tcs_pkg::t_palette_bank       o_palettes
);
    import tcs_pkg::*;

    t_palette_bank r_pal;
    t_palette_bank n_pal;

    always_comb begin
        n_pal = r_pal;
        if (i_we) begin
            if (i_index == REG_PALETTE_ZERO) begin
                n_pal[0] = i_data;
            end else if (i_index == REG_PALETTE_ONE) begin
                n_pal[1] = i_data;
            end else if (i_index == REG_PALETTE_TWO) begin
                n_pal[2] = i_data;
            end else if (i_index == REG_PALETTE_THREE) begin
                n_pal[3] = i_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal <= '0;
        end else begin
            r_pal <= n_pal;
        end
    end

    assign o_palettes = r_pal;

endmodule

// ===== hw/rtl/tcs_shade.sv =====
// tcs_shade: column pick, palette shading and row packing for one tile
// depends on tcs_pkg
module tcs_shade (
    input  tcs_pkg::t_tile_req     i_req,
    input  tcs_pkg::t_palette_bank i_palettes,
    output tcs_pkg::t_shade_res    o_res
);
    import tcs_pkg::*;

    logic [PAL_W-1:0]    pal;
    logic [2:0]          col;
    logic [COLUMN_W-1:0] word;
    logic                nonzero;
    logic [ROW_W-1:0]    row [ROWS];
    logic [PIX_W-1:0]    pix [ROWS];
    logic [PIX_W-1:0]    shade [ROWS];

    assign pal     = i_palettes[i_req.palette_select];
    assign col     = i_req.mirror_horizontal ? ~i_req.pixel_column : i_req.pixel_column;
    assign nonzero = (|i_req.rows_low) | (|i_req.rows_high);

    always_comb begin
        word = '0;
        for (int r = 0; r < ROWS; r++) begin
            if (r < ROWS / 2) begin
                row[r] = i_req.rows_low[r*ROW_W +: ROW_W];
            end else begin
                row[r] = i_req.rows_high[(r - ROWS / 2)*ROW_W +: ROW_W];
            end
            pix[r] = row[r][{col, 1'b0} +: PIX_W];
            // color zero stays transparent
            if (pix[r] == '0) begin
                shade[r] = '0;
            end else begin
                shade[r] = pal[{pix[r], 1'b0} +: PIX_W];
            end
            if (i_req.mirror_vertical) begin
                word[(ROWS - 1 - r)*PIX_W +: PIX_W] = shade[r];
            end else begin
                word[r*PIX_W +: PIX_W] = shade[r];
            end
        end
    end

    assign o_res.column_word  = nonzero ? word : '0;
    assign o_res.write_enable = nonzero;

endmodule
